>>> sv/assert_macros.svh
// Assertion helpers for the tile and sprite pixel renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define TSPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TSPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/tspr_pkg.sv
// ----------------------------------------------------------------------------
// tspr_pkg
// Shared constants, op codes and color lookup for the pixel renderer.
// ----------------------------------------------------------------------------
package tspr_pkg;

  localparam int SPRITE_COUNT = 8;
  localparam int VRAM_BYTES   = 2048;
  localparam int VRAM_AW      = $clog2(VRAM_BYTES);

  typedef enum logic [3:0] {
    OP_BUS_WR   = 4'd0,
    OP_BUS_RD   = 4'd1,
    OP_POS_WR   = 4'd2,
    OP_TILE_LD  = 4'd3,
    OP_SPR_LD   = 4'd4,
    OP_PAL_LD   = 4'd5,
    OP_COLOR_LD = 4'd6,
    OP_RENDER   = 4'd7,
    OP_TICK     = 4'd8
  } op_t;

  localparam logic [8:0] SCAN_RESET   = 9'd248;
  localparam logic [8:0] SCAN_IRQ_SET = 9'd496;
  localparam logic [8:0] SCAN_IRQ_CLR = 9'd272;
  localparam logic [8:0] SCAN_LAST    = 9'd511;

  localparam logic [7:0] RG_LEVELS [8] = '{8'h00, 8'h21, 8'h47, 8'h68,
                                          8'h97, 8'hB8, 8'hDE, 8'hFF};
  localparam logic [7:0] B_LEVELS  [4] = '{8'h00, 8'h51, 8'hAE, 8'hFF};

  function automatic logic [23:0] rgb_of(input logic [7:0] c);
    rgb_of = {B_LEVELS[c[7:6]], RG_LEVELS[c[5:3]], RG_LEVELS[c[2:0]]};
  endfunction

endpackage

>>> sv/tspr_ram.sv
// ----------------------------------------------------------------------------
// tspr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tspr_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tile_sprite_pixel_renderer.sv
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer
// Tile map and sprite pixel generator with bus access to its video stores.
// ----------------------------------------------------------------------------
// One item is taken at a time and every item gives exactly one result.
// Writes, loads, line ticks, unused op codes and renders outside the picture
// go straight to the output stage; a bus read first reads the video RAM or
// the attribute store. A render walks the sprites in order: it reads each
// sprite's position and attribute bytes and tests for a hit; on a hit it
// reads the sprite pattern and palette, and stops at the first opaque sprite
// pixel to read its color. If no sprite pixel is opaque it reads the two video
// RAM bytes per tile, then the tile pattern, palette and color lookups. Each
// store has a single read port, so every lookup is one synchronous read in
// sequence.
// A new item is accepted while the previous result still waits on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tile_sprite_pixel_renderer
  import tspr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: bus_address[15:0], bus_data[23:16], render_line[31:24],
  //           render_column[40:32], zero fill [47:41]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [3:0]  in_tuser,   // op[3:0]
  // out_tdata: read_data[7:0], pixel_rgb[31:8], irq_level[32], zero [39:33]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_RD   = 15'h0002,  // issue bus read
    S_RDW  = 15'h0004,  // bus read data back
    S_SPA  = 15'h0008,  // issue even position/attr read
    S_SPB  = 15'h0010,  // capture even, issue odd
    S_SPC  = 15'h0020,  // hit test, issue sprite pattern read
    S_SPD  = 15'h0040,  // sprite pixel, issue palette read
    S_SPE  = 15'h0080,  // sprite pen, transparent or color read
    S_BGA  = 15'h0100,  // issue tile code read
    S_BGB  = 15'h0200,  // issue tile palette read
    S_BGC  = 15'h0400,  // issue tile pattern read
    S_BGD  = 15'h0800,  // tile pixel, issue palette read
    S_BGE  = 15'h1000,  // issue color read
    S_COL  = 15'h2000,  // color back, build rgb
    S_OUT  = 15'h4000   // hold result until output is free
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  logic [3:0]  op_r;
  logic [15:0] addr_r;
  logic [7:0]  line_r;
  logic [8:0]  col_r;

  logic [2:0]  spr_r, spr_nxt;
  logic [7:0]  sp_top_r, sp_attr_r, sp_pal_r;
  logic        sp_yf_r;
  logic [1:0]  sp_k_r;
  logic [VRAM_AW-1:0] bg_addr_r;
  logic [7:0]  bg_tile_r;
  logic [5:0]  bg_pal_r;

  logic [7:0]  res_rd_r;
  logic [23:0] res_rgb_r;
  logic        out_valid_r;
  logic [7:0]  out_rd_r;
  logic [23:0] out_rgb_r;
  logic        out_irq_r;

  logic [8:0]  scan_r;
  logic        irq_r;

  // input fields
  logic [3:0]  in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic        acc;
  assign in_op   = in_tuser;
  assign in_addr = in_tdata[15:0];
  assign in_data = in_tdata[23:16];
  assign acc     = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // bus map decode
  logic in_vram_hit, in_attr_hit, r_vram_hit, r_attr_hit;
  assign in_vram_hit = (in_addr[15:11] == 5'b01000);
  assign in_attr_hit = (in_addr[15:4] == 12'h4FF);
  assign r_vram_hit  = (addr_r[15:11] == 5'b01000);
  assign r_attr_hit  = (addr_r[15:4] == 12'h4FF);

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic [VRAM_AW-1:0] vram_raddr;
  logic [3:0]  attr_raddr, pos_raddr;
  logic [11:0] spr_raddr;
  logic [7:0]  pal_raddr;
  logic [4:0]  col_raddr;
  logic [7:0]  vram_rdata, attr_rdata, pos_rdata, tile_rdata, spr_rdata;
  logic [7:0]  pal_rdata, col_rdata;

  tspr_ram #(.AW(VRAM_AW), .DW(8)) u_vram (
    .clk, .we(acc && in_op == OP_BUS_WR && in_vram_hit),
    .waddr(in_addr[VRAM_AW-1:0]), .wdata(in_data),
    .raddr(vram_raddr), .rdata(vram_rdata));

  tspr_ram #(.AW(4), .DW(8)) u_attr (
    .clk, .we(acc && in_op == OP_BUS_WR && in_attr_hit),
    .waddr(in_addr[3:0]), .wdata(in_data),
    .raddr(attr_raddr), .rdata(attr_rdata));

  tspr_ram #(.AW(4), .DW(8)) u_pos (
    .clk, .we(acc && in_op == OP_POS_WR),
    .waddr(in_addr[3:0]), .wdata(in_data),
    .raddr(pos_raddr), .rdata(pos_rdata));

  tspr_ram #(.AW(12), .DW(8)) u_tile (
    .clk, .we(acc && in_op == OP_TILE_LD),
    .waddr(in_addr[11:0]), .wdata(in_data),
    .raddr({bg_tile_r, ~col_r[2], line_r[2:0]}), .rdata(tile_rdata));

  tspr_ram #(.AW(12), .DW(8)) u_spr (
    .clk, .we(acc && in_op == OP_SPR_LD),
    .waddr(in_addr[11:0]), .wdata(in_data),
    .raddr(spr_raddr), .rdata(spr_rdata));

  tspr_ram #(.AW(8), .DW(8)) u_pal (
    .clk, .we(acc && in_op == OP_PAL_LD),
    .waddr(in_addr[7:0]), .wdata(in_data),
    .raddr(pal_raddr), .rdata(pal_rdata));

  tspr_ram #(.AW(5), .DW(8)) u_color (
    .clk, .we(acc && in_op == OP_COLOR_LD),
    .waddr(in_addr[4:0]), .wdata(in_data),
    .raddr(col_raddr), .rdata(col_rdata));

  // ---------------------------------------------------------------------------
  // Background tile address: two rotated border columns on each side
  // ---------------------------------------------------------------------------
  logic [4:0]  bg_row;
  logic [5:0]  bg_t;
  logic [10:0] bg_full;
  assign bg_row = line_r[7:3];
  assign bg_t   = col_r[8:3];
  always_comb begin
    if (bg_t < 6'd2) begin
      bg_full = 11'h3C2 + {6'd0, bg_row} + {bg_t[4:0], 5'd0};
    end else if (bg_t < 6'd34) begin
      bg_full = 11'h040 + {1'b0, bg_row, 5'd0} + {5'd0, bg_t - 6'd2};
    end else begin
      bg_full = 11'h002 + {6'd0, bg_row} + {(bg_t[4:0] - 5'd2), 5'd0};
    end
  end

  // ---------------------------------------------------------------------------
  // Sprite hit test and pattern address (10-bit two's complement offsets)
  // ---------------------------------------------------------------------------
  logic [9:0]  d_y, d_x;
  logic        sp_hit, sp_xf, sp_yf;
  logic [2:0]  sp_low;
  logic [4:0]  sp_grp8, sp_off;
  logic [11:0] sp_base;
  assign d_y = {2'b0, line_r} + 10'd31 - {9'd0, (spr_r < 3'd3)} - {2'b0, sp_top_r};
  assign d_x = {1'b0, col_r} + {2'b0, pos_rdata} - 10'd272;
  assign sp_hit  = (d_y[9:4] == 6'd0) && (d_x[9:4] == 6'd0);
  assign sp_yf   = sp_attr_r[0];
  assign sp_xf   = sp_attr_r[1];
  assign sp_low  = sp_xf ? (d_y[2:0] ^ 3'd7) : d_y[2:0];
  assign sp_base = {sp_attr_r[7:2], d_y[3] ^ sp_xf, 2'b00, sp_low};
  assign sp_grp8 = {d_x[3:2], 3'b000};
  assign sp_off  = sp_yf ? (5'd0 - sp_grp8) : (5'd8 + sp_grp8);
  assign spr_raddr = sp_base + {7'd0, sp_off};

  // pixel extraction from pattern bytes
  logic [1:0] sp_pix, bg_pix;
  assign sp_pix = sp_yf_r ? {spr_rdata[3'd4 + {1'b0, sp_k_r}], spr_rdata[{1'b0, sp_k_r}]}
                          : {spr_rdata[3'd7 - {1'b0, sp_k_r}], spr_rdata[3'd3 - {1'b0, sp_k_r}]};
  assign bg_pix = {tile_rdata[3'd7 - {1'b0, col_r[1:0]}],
                   tile_rdata[3'd3 - {1'b0, col_r[1:0]}]};

  // ---------------------------------------------------------------------------
  // Read address muxing
  // ---------------------------------------------------------------------------
  always_comb begin
    vram_raddr = addr_r[VRAM_AW-1:0];
    attr_raddr = addr_r[3:0];
    pos_raddr  = {spr_r, 1'b0};
    pal_raddr  = {sp_pal_r[5:0], sp_pix};
    col_raddr  = pal_rdata[4:0];
    case (state_r)
      S_BGA:   vram_raddr = bg_full[VRAM_AW-1:0];
      S_BGB:   vram_raddr = bg_addr_r ^ 11'h400;
      S_SPA:   attr_raddr = {spr_r, 1'b0};
      S_SPB: begin
        attr_raddr = {spr_r, 1'b1};
        pos_raddr  = {spr_r, 1'b1};
      end
      S_BGD:   pal_raddr = {bg_pal_r, bg_pix};
      default: ;
    endcase
  end

  logic last_spr;
  assign last_spr = (spr_r == 3'(SPRITE_COUNT - 1));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    spr_nxt   = spr_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_op == OP_BUS_RD) begin
            state_nxt = S_RD;
          end else if (in_op == OP_RENDER && in_tdata[31:24] < 8'd224 &&
                       in_tdata[40:32] < 9'd288) begin
            state_nxt = S_SPA;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD:  state_nxt = S_RDW;
      S_RDW: state_nxt = S_OUT;
      S_SPA: state_nxt = S_SPB;
      S_SPB: state_nxt = S_SPC;
      S_SPC: begin
        if (sp_hit) begin
          state_nxt = S_SPD;
        end else if (last_spr) begin
          state_nxt = S_BGA;
        end else begin
          spr_nxt   = spr_r + 3'd1;
          state_nxt = S_SPA;
        end
      end
      S_SPD: state_nxt = S_SPE;
      S_SPE: begin
        if (pal_rdata[4:0] != 5'd0) begin
          state_nxt = S_COL;
        end else if (last_spr) begin
          state_nxt = S_BGA;
        end else begin
          spr_nxt   = spr_r + 3'd1;
          state_nxt = S_SPA;
        end
      end
      S_BGA: state_nxt = S_BGB;
      S_BGB: state_nxt = S_BGC;
      S_BGC: state_nxt = S_BGD;
      S_BGD: state_nxt = S_BGE;
      S_BGE: state_nxt = S_COL;
      S_COL: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spr_r       <= 3'd0;
      out_valid_r <= 1'b0;
      scan_r      <= SCAN_RESET;
      irq_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      spr_r   <= (state_r == S_IDLE) ? 3'd0 : spr_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // line tick: irq set at count 496, cleared at 272, count wraps to 248
      if (acc && in_op == OP_TICK) begin
        if (scan_r == SCAN_IRQ_SET) begin
          irq_r <= 1'b1;
        end else if (scan_r == SCAN_IRQ_CLR) begin
          irq_r <= 1'b0;
        end
        scan_r <= (scan_r == SCAN_LAST) ? SCAN_RESET : scan_r + 9'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r      <= in_op;
      addr_r    <= in_addr;
      line_r    <= in_tdata[31:24];
      col_r     <= in_tdata[40:32];
      res_rd_r  <= 8'd0;
      res_rgb_r <= 24'd0;
    end
    case (state_r)
      S_RDW: begin
        if (r_vram_hit) begin
          res_rd_r <= vram_rdata;
        end else if (r_attr_hit) begin
          res_rd_r <= attr_rdata;
        end
      end
      S_SPB: begin
        sp_top_r  <= pos_rdata;
        sp_attr_r <= attr_rdata;
      end
      S_SPC: begin
        sp_yf_r  <= sp_yf;
        sp_k_r   <= d_x[1:0];
        sp_pal_r <= attr_rdata;
      end
      S_BGA:   bg_addr_r <= bg_full[VRAM_AW-1:0];
      S_BGB:   bg_tile_r <= vram_rdata;
      S_BGC:   bg_pal_r  <= vram_rdata[5:0];
      S_COL:   res_rgb_r <= rgb_of(col_rdata);
      S_OUT: begin
        // irq level travels with its result; a later tick may land while it waits
        if (!out_valid_r || out_tready) begin
          out_rd_r  <= res_rd_r;
          out_rgb_r <= res_rgb_r;
          out_irq_r <= irq_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_irq_r, out_rgb_r, out_rd_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TSPR_ASSERT(a_state_onehot, $onehot(state_r), "state register not one-hot")
  `TSPR_ASSERT(a_busy_after_accept, acc |=> (state_r != S_IDLE), "accept left sequencer idle")
  `TSPR_ASSERT(a_scan_range, scan_r >= SCAN_RESET, "line counter below wrap value")
  `TSPR_ASSERT_ALWAYS(a_rd_only_busread,
    (state_r == S_RDW) |-> (op_r == OP_BUS_RD), "read data path entered for non-read op")

endmodule
